@@ design/clcd_tbs_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_tbs_pkg
// Shared types and constants for the character LCD text buffer sync unit.
// ----------------------------------------------------------------------------
package clcd_tbs_pkg;

    localparam int DEF_COLUMNS = 20;
    localparam int DEF_ROWS    = 4;
    localparam int MAX_RESULTS = 30;

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
    localparam logic [7:0] ROW_ODD_OFFSET = 8'h40;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GOTO  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SYNC  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_BLANK,
        S_PUT,
        S_CLEAR,
        S_SYNC_RD,
        S_SYNC_CMP,
        S_PUSH_CMD,
        S_PUSH_DATA,
        S_SYNC_END
    } state_t;

endpackage

@@ design/char_lcd_text_buffer_sync_unit.sv @@
// ----------------------------------------------------------------------------
// char_lcd_text_buffer_sync_unit
// Character LCD text store with cursor, scroll and differential row sync.
//
// Input channel (in_valid/in_ready) takes one command per transaction: put
// character, goto, clear screen or sync one row. The output channel
// (out_valid/out_ready) carries the LCD bus bytes of a row sync: a set-address
// command for each run of changed cells followed by its data bytes, with last
// marking the final byte of the sync.
// A put that wraps moves to the next row before it writes; a put or newline
// past the last row first scrolls the text store up one row and blanks the
// last row. Clear blanks every cell. A row sync examines its cells one by one,
// bounded by the single read port of the two cell memories. Bytes are held one
// deep so that last can be set.
// After reset the unit sweeps both memories (spaces in the text store, zero in
// the shown copy) with in_ready low.
// A stalled receiver holds the output register; a sync then waits, while
// other commands are still accepted once the sync has finished.
// ----------------------------------------------------------------------------
module char_lcd_text_buffer_sync_unit
    import clcd_tbs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] char_code,
    input  logic [1:0] row,
    input  logic [4:0] column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       reg_select,
    output logic [7:0] bus_byte,
    output logic       last
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(CELLS);
    localparam int XW    = $clog2(COLUMNS);
    localparam int COLW  = $clog2(COLUMNS + 1);

    logic [7:0] text_mem  [CELLS];
    logic [7:0] shown_mem [CELLS];

    state_t          state_reg, state_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [COLW-1:0] cursor_col_reg, cursor_col_next;
    logic [1:0]      cursor_row_reg, cursor_row_next;
    logic [7:0]      ch_reg, ch_next;
    logic            put_pend_reg, put_pend_next;
    logic [1:0]      row_reg, row_next;
    logic [CW-1:0]   base_reg, base_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [4:0]      n_reg, n_next;
    logic            in_run_reg, in_run_next;
    logic            hold_valid_reg, hold_valid_next;
    logic            hold_rs_reg, hold_rs_next;
    logic [7:0]      hold_byte_reg, hold_byte_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_rs_reg, out_rs_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    logic [7:0]      text_rd_reg, shown_rd_reg;

    logic            text_we, shown_we, rd_en;
    logic [CW-1:0]   text_wa, shown_wa, rd_addr;
    logic [7:0]      text_wd, shown_wd;

    logic            accept, slot_free, cells_differ, at_last_col, last_row;
    logic            col_full, goto_row_hi, goto_col_hi;
    logic [CW-1:0]   cur_addr, sync_addr;
    logic [31:0]     lcd_addr;
    logic [7:0]      cmd_byte;
    logic [5:0]      n_need;

    assign accept       = in_valid && in_ready;
    assign slot_free    = !out_valid_reg || out_ready;
    assign cells_differ = text_rd_reg != shown_rd_reg;
    assign at_last_col  = 32'(x_reg) == 32'(COLUMNS - 1);
    assign last_row     = 32'(cursor_row_reg) + 32'd1 >= 32'(ROWS);
    assign col_full     = 32'(cursor_col_reg) >= 32'(COLUMNS);
    assign goto_row_hi  = 32'(row) > 32'(ROWS - 1);
    assign goto_col_hi  = 32'(column) > 32'(COLUMNS - 1);
    assign cur_addr     = CW'(32'(cursor_row_reg) * 32'(COLUMNS) + 32'(cursor_col_reg));
    assign sync_addr    = CW'(32'(base_reg) + 32'(x_reg));
    assign lcd_addr     = (row_reg[0] ? 32'(ROW_ODD_OFFSET) : 32'd0)
                        + (row_reg[1] ? 32'(COLUMNS) : 32'd0) + 32'(x_reg);
    assign cmd_byte     = CMD_SET_ADDR | {1'b0, lcd_addr[6:0]};
    assign n_need       = 6'(n_reg) + (in_run_reg ? 6'd1 : 6'd2);

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = out_valid_reg;
    assign reg_select = out_rs_reg;
    assign bus_byte   = out_byte_reg;
    assign last       = out_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (32'(ptr_reg) == 32'(CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_PUT:
                        begin
                            if (char_code == CHAR_NEWLINE)
                                state_next = last_row ? S_SCROLL : S_IDLE;
                            else if (col_full)
                                state_next = last_row ? S_SCROLL : S_PUT;
                        end
                        OP_GOTO:  state_next = S_IDLE;
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_SYNC:
                        begin
                            if (32'(row) < 32'(ROWS))
                                state_next = S_SYNC_RD;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SCROLL:
            begin
                if (32'(ptr_reg) == 32'(CELLS - COLUMNS))
                    state_next = S_BLANK;
            end
            S_BLANK:
            begin
                if (32'(ptr_reg) == 32'(CELLS - 1))
                    state_next = put_pend_reg ? S_PUT : S_IDLE;
            end
            S_PUT: state_next = S_IDLE;
            S_CLEAR:
            begin
                if (32'(ptr_reg) == 32'(CELLS - 1))
                    state_next = S_IDLE;
            end
            S_SYNC_RD: state_next = S_SYNC_CMP;
            S_SYNC_CMP:
            begin
                if (cells_differ)
                begin
                    if (n_need > 6'(MAX_RESULTS))
                        state_next = S_SYNC_END;
                    else
                        state_next = in_run_reg ? S_PUSH_DATA : S_PUSH_CMD;
                end
                else
                    state_next = at_last_col ? S_SYNC_END : S_SYNC_RD;
            end
            S_PUSH_CMD:
            begin
                if (slot_free)
                    state_next = S_PUSH_DATA;
            end
            S_PUSH_DATA:
            begin
                if (slot_free)
                    state_next = at_last_col ? S_SYNC_END : S_SYNC_RD;
            end
            S_SYNC_END:
            begin
                if (!hold_valid_reg || slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        ptr_next        = ptr_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        ch_next         = ch_reg;
        put_pend_next   = put_pend_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        x_next          = x_reg;
        n_next          = n_reg;
        in_run_next     = in_run_reg;
        hold_valid_next = hold_valid_reg;
        hold_rs_next    = hold_rs_reg;
        hold_byte_next  = hold_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_rs_next     = out_rs_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        text_we         = 1'b0;
        text_wa         = cur_addr;
        text_wd         = CHAR_SPACE;
        shown_we        = 1'b0;
        shown_wa        = sync_addr;
        shown_wd        = text_rd_reg;
        rd_en           = 1'b0;
        rd_addr         = sync_addr;
        unique case (state_reg)
            S_INIT:
            begin
                text_we  = 1'b1;
                text_wa  = ptr_reg;
                shown_we = 1'b1;
                shown_wa = ptr_reg;
                shown_wd = 8'd0;
                ptr_next = CW'(32'(ptr_reg) + 32'd1);
                if (32'(ptr_reg) == 32'(CELLS - 1))
                    ptr_next = '0;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next       = char_code;
                    ptr_next      = '0;
                    put_pend_next = char_code != CHAR_NEWLINE;
                    unique case (op_t'(op))
                        OP_PUT:
                        begin
                            if (char_code == CHAR_NEWLINE || col_full)
                            begin
                                cursor_col_next = '0;
                                if (last_row)
                                    cursor_row_next = 2'(ROWS - 1);
                                else
                                    cursor_row_next = cursor_row_reg + 2'd1;
                            end
                            else
                            begin
                                text_we         = 1'b1;
                                text_wd         = char_code;
                                cursor_col_next = cursor_col_reg + COLW'(1);
                            end
                        end
                        OP_GOTO:
                        begin
                            cursor_row_next = goto_row_hi ? 2'(ROWS - 1) : row;
                            cursor_col_next = goto_col_hi ? COLW'(COLUMNS - 1) : COLW'(column);
                        end
                        OP_CLEAR:
                        begin
                            cursor_col_next = '0;
                            cursor_row_next = '0;
                        end
                        OP_SYNC:
                        begin
                            row_next    = row;
                            base_next   = CW'(32'(row) * 32'(COLUMNS));
                            x_next      = '0;
                            n_next      = '0;
                            in_run_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCROLL:
            begin
                if (32'(ptr_reg) < 32'(CELLS - COLUMNS))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = CW'(32'(ptr_reg) + 32'(COLUMNS));
                    ptr_next = CW'(32'(ptr_reg) + 32'd1);
                end
                if (ptr_reg != '0)
                begin
                    text_we = 1'b1;
                    text_wa = CW'(32'(ptr_reg) - 32'd1);
                    text_wd = text_rd_reg;
                end
            end
            S_BLANK:
            begin
                text_we  = 1'b1;
                text_wa  = ptr_reg;
                ptr_next = CW'(32'(ptr_reg) + 32'd1);
            end
            S_PUT:
            begin
                text_we         = 1'b1;
                text_wd         = ch_reg;
                cursor_col_next = cursor_col_reg + COLW'(1);
            end
            S_CLEAR:
            begin
                text_we  = 1'b1;
                text_wa  = ptr_reg;
                ptr_next = CW'(32'(ptr_reg) + 32'd1);
            end
            S_SYNC_RD:
            begin
                rd_en = 1'b1;
            end
            S_SYNC_CMP:
            begin
                if (cells_differ)
                begin
                    if (n_need <= 6'(MAX_RESULTS))
                    begin
                        shown_we    = 1'b1;
                        in_run_next = 1'b1;
                    end
                end
                else
                begin
                    in_run_next = 1'b0;
                    x_next      = XW'(32'(x_reg) + 32'd1);
                end
            end
            S_PUSH_CMD, S_PUSH_DATA:
            begin
                if (slot_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_rs_next    = hold_rs_reg;
                        out_byte_next  = hold_byte_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    n_next          = n_reg + 5'd1;
                    if (state_reg == S_PUSH_CMD)
                    begin
                        hold_rs_next   = 1'b0;
                        hold_byte_next = cmd_byte;
                    end
                    else
                    begin
                        hold_rs_next   = 1'b1;
                        hold_byte_next = text_rd_reg;
                        x_next         = XW'(32'(x_reg) + 32'd1);
                    end
                end
            end
            S_SYNC_END:
            begin
                if (hold_valid_reg && slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rs_next     = hold_rs_reg;
                    out_byte_next   = hold_byte_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
            text_mem[text_wa] <= text_wd;
        if (shown_we)
            shown_mem[shown_wa] <= shown_wd;
        if (rd_en)
        begin
            text_rd_reg  <= text_mem[rd_addr];
            shown_rd_reg <= shown_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        row_reg       <= row_next;
        base_reg      <= base_next;
        hold_rs_reg   <= hold_rs_next;
        hold_byte_reg <= hold_byte_next;
        out_rs_reg    <= out_rs_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ptr_reg        <= '0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            put_pend_reg   <= 1'b0;
            x_reg          <= '0;
            n_reg          <= '0;
            in_run_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            put_pend_reg   <= put_pend_next;
            x_reg          <= x_next;
            n_reg          <= n_next;
            in_run_reg     <= in_run_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !hold_valid_reg)
        else $error("held bus byte left behind after sync");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 5'(MAX_RESULTS))
        else $error("sync emitted too many bus bytes");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SYNC_CMP |-> $past(state_reg) == S_SYNC_RD)
        else $error("compare without preceding memory read");

    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_row_reg) < 32'(ROWS))
        else $error("cursor row out of range");

    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_col_reg) <= 32'(COLUMNS))
        else $error("cursor column out of range");

endmodule
